[hw/rtl/rrs_pkg.sv]
// Shared types and constants for the round robin sleep scheduler.
package rrs_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int CMD_W      = 2;
  localparam int SLEEP_W    = 32;
  localparam int SLICE_W    = 16;
  localparam int SLOT_OUT_W = 4;
  localparam int STATUS_W   = 2;

  localparam logic [SLICE_W-1:0] SLICE_TICKS_RST = 16'd16;
  localparam logic [SLICE_W-1:0] SLICE_MAX       = '1;

  typedef enum logic [1:0] {
    ST_RUNNABLE,
    ST_RUNNING,
    ST_BLOCKED,
    ST_DEAD
  } slot_state_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK,
    CMD_SLEEP,
    CMD_EXIT,
    CMD_FORK
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_ZERO_SLEEP,
    STAT_NO_SLOT
  } status_t;

  typedef struct packed {
    slot_state_t        st;
    logic [SLEEP_W-1:0] sleep_left;
    logic [SLICE_W-1:0] slice_used;
  } slot_row_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] running_slot;
    logic                  switched;
    logic [SLOT_OUT_W-1:0] child_slot;
    status_t               status;
  } rsp_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_TICK_SCAN,
    CS_FORK_SCAN,
    CS_SW_RD,
    CS_SW_WR_NEXT,
    CS_SW_WR_CUR,
    CS_FINISH
  } ctl_state_t;

endpackage

[hw/rtl/rrs_if.sv]
// Request and response channel interfaces of the scheduler.
interface rrs_req_if;
  import rrs_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [SLEEP_W-1:0] sleep_ticks;

  modport source (output valid, command, sleep_ticks, input ready);
  modport sink   (input valid, command, sleep_ticks, output ready);
endinterface

interface rrs_rsp_if;
  import rrs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SLOT_OUT_W-1:0] running_slot;
  logic                  switched;
  logic [SLOT_OUT_W-1:0] child_slot;
  logic [STATUS_W-1:0]   status;

  modport source (output valid, running_slot, switched, child_slot, status, input ready);
  modport sink   (input valid, running_slot, switched, child_slot, status, output ready);
endinterface

[hw/rtl/rrs_slot_ram.sv]
// Slot table: one row per slot, one read and one write port, per-row valid bits.
module rrs_slot_ram #(
  parameter int SLOTS = rrs_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  rrs_pkg::slot_row_t       wr_row,
  output rrs_pkg::slot_row_t       rd_row
);
  import rrs_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  slot_row_t        mem [SLOTS];
  logic [SLOTS-1:0] row_valid;
  slot_row_t        q_row;
  logic             q_valid;
  logic [IDX_W-1:0] q_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      q_row  <= mem[rd_addr];
      q_addr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      q_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_valid <= row_valid[rd_addr];
      end
    end
  end

  // never-written row reads as its reset value: slot 0 running, rest dead
  always_comb begin
    if (q_valid) begin
      rd_row = q_row;
    end else begin
      rd_row.st         = (q_addr == '0) ? ST_RUNNING : ST_DEAD;
      rd_row.sleep_left = '0;
      rd_row.slice_used = '0;
    end
  end

endmodule

[hw/rtl/rrs_slot_alu.sv]
// Per-row tick update: command effect, sleep countdown, slice count.
module rrs_slot_alu (
  input  rrs_pkg::slot_row_t           row_in,
  input  logic                         is_cur,
  input  rrs_pkg::cmd_t                cmd,
  input  logic [rrs_pkg::SLEEP_W-1:0]  sleep_ticks,
  output rrs_pkg::slot_row_t           row_out
);
  import rrs_pkg::*;

  slot_row_t row_mod;

  always_comb begin
    row_mod = row_in;
    if (is_cur && cmd == CMD_SLEEP) begin
      row_mod.st         = ST_BLOCKED;
      row_mod.sleep_left = sleep_ticks;
    end else if (is_cur && cmd == CMD_EXIT) begin
      row_mod.st = ST_DEAD;
    end

    row_out = row_mod;
    if (row_mod.st == ST_BLOCKED) begin
      if (row_mod.sleep_left <= SLEEP_W'(1)) begin
        row_out.sleep_left = '0;
        row_out.st         = ST_RUNNABLE;
      end else begin
        row_out.sleep_left = row_mod.sleep_left - SLEEP_W'(1);
      end
    end

    // slice count saturates
    if (is_cur && row_mod.slice_used != SLICE_MAX) begin
      row_out.slice_used = row_mod.slice_used + SLICE_W'(1);
    end
  end

endmodule

[hw/rtl/rrs_ctrl.sv]
// Sequencer: walks the slot table for ticks and forks; after a tick walk it may switch slots.
module rrs_ctrl #(
  parameter int SLOTS = rrs_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rrs_pkg::SLICE_W-1:0]  slice_ticks,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [rrs_pkg::CMD_W-1:0]    req_cmd,
  input  logic [rrs_pkg::SLEEP_W-1:0]  req_ticks,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output rrs_pkg::rsp_t                rsp_q,
  output logic                         rd_en,
  output logic [$clog2(SLOTS)-1:0]     rd_addr,
  output logic                         wr_en,
  output logic [$clog2(SLOTS)-1:0]     wr_addr,
  output rrs_pkg::slot_row_t           wr_row,
  input  rrs_pkg::slot_row_t           rd_row,
  output logic                         alu_is_cur,
  output rrs_pkg::cmd_t                alu_cmd,
  output logic [rrs_pkg::SLEEP_W-1:0]  alu_ticks,
  input  rrs_pkg::slot_row_t           alu_out
);
  import rrs_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  ctl_state_t         state, state_next;
  logic [IDX_W-1:0]   cur;
  cmd_t               cmd_q;
  logic [SLEEP_W-1:0] ticks_q;
  logic [CNT_W-1:0]   rd_idx;
  logic               p_vld;
  logic [IDX_W-1:0]   p_idx;
  logic               need_sw;
  logic               found_hi, found_lo;
  logic [IDX_W-1:0]   hi_idx, lo_idx;
  logic [IDX_W-1:0]   nxt;
  slot_row_t          cur_row;
  logic [IDX_W-1:0]   child;
  status_t            status_q;
  logic               switched_q;

  cmd_t               req_cmd_t;
  logic               scan_rd;
  logic               p_last;
  logic               is_cur;
  logic               cand;
  logic               found_hi_eff, found_lo_eff;
  logic [IDX_W-1:0]   hi_idx_eff, lo_idx_eff, nxt_eff;
  logic               need_now, need_eff, sw_go;
  logic               fork_hit;

  assign req_cmd_t = cmd_t'(req_cmd);
  assign scan_rd   = (state == CS_TICK_SCAN || state == CS_FORK_SCAN)
                     && (rd_idx < CNT_W'(SLOTS));
  assign p_last    = (p_idx == IDX_W'(SLOTS - 1));
  assign is_cur    = (p_idx == cur);

  assign alu_is_cur = is_cur;
  assign alu_cmd    = cmd_q;
  assign alu_ticks  = ticks_q;

  // round robin search folded into the pass: first runnable above cur wins,
  // else the first runnable below it
  assign cand         = p_vld && !is_cur && alu_out.st == ST_RUNNABLE;
  assign found_hi_eff = found_hi || (cand && p_idx > cur);
  assign found_lo_eff = found_lo || (cand && p_idx < cur);
  assign hi_idx_eff   = found_hi ? hi_idx : p_idx;
  assign lo_idx_eff   = found_lo ? lo_idx : p_idx;
  assign nxt_eff      = found_hi_eff ? hi_idx_eff : lo_idx_eff;
  assign need_now     = (alu_out.slice_used >= slice_ticks) || (alu_out.st != ST_RUNNING);
  assign need_eff     = is_cur ? need_now : need_sw;
  assign sw_go        = need_eff && (found_hi_eff || found_lo_eff);
  assign fork_hit     = p_vld && rd_row.st == ST_DEAD;

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (req_valid) begin
          if (req_cmd_t == CMD_FORK) begin
            state_next = CS_FORK_SCAN;
          end else if (req_cmd_t == CMD_SLEEP && req_ticks == '0) begin
            state_next = CS_FINISH;
          end else begin
            state_next = CS_TICK_SCAN;
          end
        end
      end
      CS_TICK_SCAN: begin
        if (p_vld && p_last) begin
          state_next = sw_go ? CS_SW_RD : CS_FINISH;
        end
      end
      CS_FORK_SCAN: begin
        if (fork_hit || (p_vld && p_last)) begin
          state_next = CS_FINISH;
        end
      end
      CS_SW_RD:      state_next = CS_SW_WR_NEXT;
      CS_SW_WR_NEXT: state_next = CS_SW_WR_CUR;
      CS_SW_WR_CUR:  state_next = CS_FINISH;
      CS_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    rd_en     = scan_rd;
    rd_addr   = rd_idx[IDX_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = p_idx;
    wr_row    = alu_out;
    case (state)
      CS_IDLE: begin
        req_ready = 1'b1;
      end
      CS_TICK_SCAN: begin
        wr_en = p_vld;
      end
      CS_FORK_SCAN: begin
        wr_en             = fork_hit;
        wr_row.st         = ST_RUNNABLE;
        wr_row.sleep_left = '0;
        wr_row.slice_used = '0;
      end
      CS_SW_RD: begin
        rd_en   = 1'b1;
        rd_addr = nxt;
      end
      CS_SW_WR_NEXT: begin
        wr_en     = 1'b1;
        wr_addr   = nxt;
        wr_row    = rd_row;
        wr_row.st = ST_RUNNING;
      end
      CS_SW_WR_CUR: begin
        wr_en             = 1'b1;
        wr_addr           = cur;
        wr_row            = cur_row;
        wr_row.st         = (cur_row.st == ST_RUNNING) ? ST_RUNNABLE : cur_row.st;
        wr_row.slice_used = '0;
      end
      CS_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_IDLE;
      cur       <= '0;
      p_vld     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      p_vld <= scan_rd;
      if (state == CS_SW_WR_CUR) begin
        cur <= nxt;
      end
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (state == CS_FINISH && state_next == CS_IDLE) begin
        rsp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == CS_IDLE && req_valid) begin
      cmd_q      <= req_cmd_t;
      ticks_q    <= req_ticks;
      rd_idx     <= (req_cmd_t == CMD_FORK) ? CNT_W'(1) : '0;
      found_hi   <= 1'b0;
      found_lo   <= 1'b0;
      need_sw    <= 1'b0;
      child      <= '0;
      switched_q <= 1'b0;
      status_q   <= (req_cmd_t == CMD_SLEEP && req_ticks == '0) ? STAT_ZERO_SLEEP : STAT_OK;
    end
    if (scan_rd) begin
      rd_idx <= rd_idx + CNT_W'(1);
      p_idx  <= rd_idx[IDX_W-1:0];
    end
    if (state == CS_TICK_SCAN && p_vld) begin
      found_hi <= found_hi_eff;
      found_lo <= found_lo_eff;
      hi_idx   <= hi_idx_eff;
      lo_idx   <= lo_idx_eff;
      nxt      <= nxt_eff;
      need_sw  <= need_eff;
      if (is_cur) begin
        cur_row <= alu_out;
      end
    end
    if (state == CS_FORK_SCAN && p_vld) begin
      if (fork_hit) begin
        child <= p_idx;
      end else if (p_last) begin
        status_q <= STAT_NO_SLOT;
      end
    end
    if (state == CS_SW_WR_CUR) begin
      switched_q <= 1'b1;
    end
    if (state == CS_FINISH && state_next == CS_IDLE) begin
      rsp_q.running_slot <= SLOT_OUT_W'(cur);
      rsp_q.switched     <= switched_q;
      rsp_q.child_slot   <= SLOT_OUT_W'(child);
      rsp_q.status       <= status_q;
    end
  end

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("slot table read and write hit the same row");

  a_switch_target: assert property (@(posedge clk) disable iff (rst)
    state == CS_SW_WR_CUR |-> nxt != cur)
    else $error("switch target is the current slot");

  a_fork_skips_zero: assert property (@(posedge clk) disable iff (rst)
    state == CS_FORK_SCAN && p_vld |-> p_idx != '0)
    else $error("fork scan reached slot 0");

  a_no_slot_child: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_q.status == STAT_NO_SLOT |-> rsp_q.child_slot == '0)
    else $error("failed fork reports a child slot");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    state == CS_SW_WR_CUR |=> cur <= IDX_W'(SLOTS - 1))
    else $error("current slot out of range after switch");
`endif

endmodule

[hw/rtl/round_robin_sleep_scheduler_top.sv]
// Top level of the round robin sleep scheduler.
//
// Usage:
//   req  : valid/ready request channel, command (0 tick, 1 sleep, 2 exit, 3 fork)
//          and sleep_ticks. A request is taken when valid and ready are high.
//   rsp  : valid/ready response channel, one response per request:
//          running_slot, switched, child_slot, status.
//   cfg  : cfg_we/cfg_wdata write slice_ticks; write only while idle.
// Throughput: one request at a time. The sequencer walks the slot
//   table one row per cycle through its single read and write port.
//   Tick, sleep, exit: walk every row, then rewrite the new and old slot if
//   the current slot changes. Fork: stop at the first dead slot. Zero sleep:
//   skip the walk. The next request is taken in idle after a response loads.
// Reset: slot 0 running, all other slots dead, counts zero, slice_ticks 16;
//   the table comes out of reset at once through per-row valid bits.
// Stall: a response waits in its output register; one further request is
//   taken and worked meanwhile, and it holds in its last step until the
//   waiting response has been taken.
module round_robin_sleep_scheduler_top #(
  parameter int SLOTS = rrs_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rrs_pkg::SLICE_W-1:0] cfg_wdata,
  rrs_req_if.sink                     req,
  rrs_rsp_if.source                   rsp
);
  import rrs_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  logic [SLICE_W-1:0] slice_ticks;

  // slot table port
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  slot_row_t          wr_row;
  slot_row_t          rd_row;

  // shared row update unit
  logic               alu_is_cur;
  cmd_t               alu_cmd;
  logic [SLEEP_W-1:0] alu_ticks;
  slot_row_t          alu_out;

  rsp_t               rsp_q;

  // slice length register
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_ticks <= SLICE_TICKS_RST;
    end else if (cfg_we) begin
      slice_ticks <= cfg_wdata;
    end
  end

  rrs_slot_ram #(.SLOTS(SLOTS)) u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row),
    .rd_row  (rd_row)
  );

  // the row just read goes through the update unit on its way back
  rrs_slot_alu u_alu (
    .row_in      (rd_row),
    .is_cur      (alu_is_cur),
    .cmd         (alu_cmd),
    .sleep_ticks (alu_ticks),
    .row_out     (alu_out)
  );

  rrs_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .slice_ticks (slice_ticks),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_cmd     (req.command),
    .req_ticks   (req.sleep_ticks),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_q       (rsp_q),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_row      (wr_row),
    .rd_row      (rd_row),
    .alu_is_cur  (alu_is_cur),
    .alu_cmd     (alu_cmd),
    .alu_ticks   (alu_ticks),
    .alu_out     (alu_out)
  );

  assign rsp.running_slot = rsp_q.running_slot;
  assign rsp.switched     = rsp_q.switched;
  assign rsp.child_slot   = rsp_q.child_slot;
  assign rsp.status       = rsp_q.status;

endmodule

[bench/rrs_checker.sv]
// Scheduler response checker: predicts each response from the accepted requests.
`timescale 1ns / 100ps

module rrs_checker #(
  parameter int SLOTS = rrs_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rrs_pkg::SLICE_W-1:0]    cfg_wdata,
  input  logic                           req_valid,
  input  logic                           req_ready,
  input  logic [rrs_pkg::CMD_W-1:0]      req_command,
  input  logic [rrs_pkg::SLEEP_W-1:0]    req_sleep_ticks,
  input  logic                           rsp_valid,
  input  logic                           rsp_ready,
  input  logic [rrs_pkg::SLOT_OUT_W-1:0] rsp_running_slot,
  input  logic                           rsp_switched,
  input  logic [rrs_pkg::SLOT_OUT_W-1:0] rsp_child_slot,
  input  logic [rrs_pkg::STATUS_W-1:0]   rsp_status,
  output int                             fail_count,
  output int                             outstanding
);
  import rrs_pkg::*;

  slot_state_t        proc_st    [SLOTS];
  logic [SLEEP_W-1:0] proc_sleep [SLOTS];
  logic [SLICE_W-1:0] proc_slice [SLOTS];
  int unsigned        cur_slot;
  logic [SLICE_W-1:0] slice_limit;
  rsp_t               replies_due[$];

  function automatic void reset_table();
    for (int i = 0; i < SLOTS; i++) begin
      proc_st[i]    = ST_DEAD;
      proc_sleep[i] = '0;
      proc_slice[i] = '0;
    end
    proc_st[0]  = ST_RUNNING;
    cur_slot    = 0;
    slice_limit = SLICE_TICKS_RST;
  endfunction

  // One scheduler tick: count down sleepers, charge the slice, maybe switch.
  function automatic void run_tick();
    int unsigned nxt;
    int unsigned cand;
    nxt = cur_slot;
    for (int i = 0; i < SLOTS; i++) begin
      if (proc_st[i] == ST_BLOCKED) begin
        if (proc_sleep[i] < 2) begin
          proc_sleep[i] = '0;
          proc_st[i]    = ST_RUNNABLE;
        end else begin
          proc_sleep[i] = proc_sleep[i] - 1'b1;
        end
      end
    end
    if (proc_slice[cur_slot] != SLICE_MAX)
      proc_slice[cur_slot] = proc_slice[cur_slot] + 1'b1;
    if (proc_slice[cur_slot] >= slice_limit || proc_st[cur_slot] != ST_RUNNING) begin
      for (int i = 1; i < SLOTS; i++) begin
        cand = (cur_slot + i) % SLOTS;
        if (nxt == cur_slot && proc_st[cand] == ST_RUNNABLE)
          nxt = cand;
      end
      if (nxt != cur_slot) begin
        proc_st[nxt] = ST_RUNNING;
        if (proc_st[cur_slot] == ST_RUNNING)
          proc_st[cur_slot] = ST_RUNNABLE;
        proc_slice[cur_slot] = '0;
        cur_slot = nxt;
      end
    end
  endfunction

  function automatic rsp_t work_out_reply(cmd_t cmd, logic [SLEEP_W-1:0] ticks);
    rsp_t        r;
    int unsigned was;
    was          = cur_slot;
    r.child_slot = '0;
    r.status     = STAT_OK;
    case (cmd)
      CMD_TICK: begin
        run_tick();
      end
      CMD_SLEEP: begin
        if (ticks == '0) begin
          r.status = STAT_ZERO_SLEEP;
        end else begin
          proc_st[cur_slot]    = ST_BLOCKED;
          proc_sleep[cur_slot] = ticks;
          run_tick();
        end
      end
      CMD_EXIT: begin
        proc_st[cur_slot] = ST_DEAD;
        run_tick();
      end
      default: begin
        // lowest dead slot from 1 upward; slot 0 is never a child
        r.status = STAT_NO_SLOT;
        for (int i = 1; i < SLOTS; i++) begin
          if (r.status == STAT_NO_SLOT && proc_st[i] == ST_DEAD) begin
            proc_st[i]    = ST_RUNNABLE;
            proc_sleep[i] = '0;
            proc_slice[i] = '0;
            r.child_slot  = SLOT_OUT_W'(i);
            r.status      = STAT_OK;
          end
        end
      end
    endcase
    r.running_slot = SLOT_OUT_W'(cur_slot);
    r.switched     = (cur_slot != was);
    return r;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    rsp_t due;
    if (rst) begin
      reset_table();
      replies_due.delete();
      fail_count  = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we)
        slice_limit = cfg_wdata;
      // a response can never belong to a request taken at the same edge
      if (rsp_valid && rsp_ready) begin
        if (replies_due.size() == 0) begin
          $error("response with nothing expected: running_slot %0d status %0d",
                 rsp_running_slot, rsp_status);
          fail_count++;
        end else begin
          due = replies_due.pop_front();
          check_field("running_slot", due.running_slot, rsp_running_slot);
          check_field("switched", due.switched, rsp_switched);
          check_field("child_slot", due.child_slot, rsp_child_slot);
          check_field("status", due.status, rsp_status);
        end
      end
      if (req_valid && req_ready)
        replies_due.push_back(work_out_reply(cmd_t'(req_command), req_sleep_ticks));
      outstanding <= replies_due.size();
    end
  end

endmodule

[bench/tb_top.sv]
// Testbench top: drives scheduler requests, paces responses and gives the verdict.
`timescale 1ns / 100ps

module tb_top;
  import rrs_pkg::*;

  localparam int SLOTS       = SLOTS_DEF;
  localparam int PHASE_ITEMS = 170;     // six random phases, roughly 1000 requests
  localparam int LONG_HOLD   = 400;     // long receiver stall, in cycles
  localparam int CYCLE_LIMIT = 1000000; // far above the slowest legal run

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [SLICE_W-1:0] cfg_wdata = '0;

  rrs_req_if req_ch ();
  rrs_rsp_if rsp_ch ();

  int          fail_count;
  int          outstanding;
  int unsigned cycles       = 0;
  int unsigned rx_hold      = 0;
  logic        rx_quiet     = 1'b0; // receiver draws no new random stalls while set
  logic        hold_off_req = 1'b0; // asks the receiver for one long stall
  logic        hold_done    = 1'b0; // long stall already served
  logic        tx_quiet     = 1'b0; // sender never pauses while set

  logic [SLICE_W-1:0] slice_plan [6] = '{16'd1, 16'd65535, 16'd2, 16'd5, 16'd16, 16'd3};

  round_robin_sleep_scheduler_top #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  rrs_checker #(.SLOTS(SLOTS)) checker_i (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .req_valid        (req_ch.valid),
    .req_ready        (req_ch.ready),
    .req_command      (req_ch.command),
    .req_sleep_ticks  (req_ch.sleep_ticks),
    .rsp_valid        (rsp_ch.valid),
    .rsp_ready        (rsp_ch.ready),
    .rsp_running_slot (rsp_ch.running_slot),
    .rsp_switched     (rsp_ch.switched),
    .rsp_child_slot   (rsp_ch.child_slot),
    .rsp_status       (rsp_ch.status),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short idle gaps, now and then a long one.
  function automatic int unsigned idle_gap();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // Response pacing. The long stall is counted down here, independent of the
  // sender, so that requests keep coming while responses back up.
  always @(posedge clk) begin : rx_pacing
    int unsigned g;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rx_hold      <= 0;
    end else begin
      if (hold_off_req && !hold_done) begin
        hold_done <= 1'b1;
        g = LONG_HOLD;
      end else if (rx_hold != 0) begin
        g = rx_hold - 1;
      end else if (!rx_quiet && $urandom_range(0, 2) == 0) begin
        g = idle_gap();
      end else begin
        g = 0;
      end
      rx_hold      <= g;
      rsp_ch.ready <= (g == 0);
    end
  end

  // Offer one request and hold it until taken. Valid stays high afterwards
  // unless a gap is drawn, so back-to-back requests see a single assignment.
  task automatic send_req(cmd_t cmd, logic [SLEEP_W-1:0] ticks);
    req_ch.valid       <= 1'b1;
    req_ch.command     <= cmd;
    req_ch.sleep_ticks <= ticks;
    do @(posedge clk); while (!req_ch.ready);
    if (!tx_quiet && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat (idle_gap()) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted response has been taken.
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // slice_ticks may only change with the scheduler idle.
  task automatic set_slice(logic [SLICE_W-1:0] v);
    drain();
    repeat (SLOTS + 8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random request mix. Ticks carry random sleep_ticks, which must be ignored.
  // Sleep counts are mostly short so blocked slots wake within the run; huge
  // counts are rare as each one can park a slot for good.
  task automatic send_random();
    int unsigned        pick;
    int unsigned        sel;
    logic [SLEEP_W-1:0] t;
    pick = $urandom_range(0, 99);
    t    = $urandom;
    if (pick < 45) begin
      send_req(CMD_TICK, t);
    end else if (pick < 65) begin
      sel = $urandom_range(0, 39);
      if (sel < 2)
        t = '0;
      else if (sel < 3)
        t = $urandom;
      else if (sel < 10)
        t = $urandom_range(13, 200);
      else
        t = $urandom_range(1, 12);
      send_req(CMD_SLEEP, t);
    end else if (pick < 77) begin
      send_req(CMD_EXIT, t);
    end else begin
      send_req(CMD_FORK, t);
    end
  endtask

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.command     = CMD_TICK;
    req_ch.sleep_ticks = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed opening, slice_ticks still at its reset value.
    send_req(CMD_TICK, '0);          // lone slot 0, no switch
    send_req(CMD_SLEEP, '0);         // zero sleep rejected, nothing moves
    repeat (16) send_req(CMD_FORK, '0); // fill slots 1..15, last fork finds none
    send_req(CMD_EXIT, '0);          // slot 0 dies, scheduler moves on
    send_req(CMD_SLEEP, '1);         // all-ones count, slot parked
    send_req(CMD_SLEEP, 32'd1);      // wakes within the same tick
    send_req(CMD_SLEEP, 32'd2);
    send_req(CMD_TICK, '1);
    send_req(CMD_EXIT, '0);
    send_req(CMD_FORK, '0);          // reclaims the lowest dead slot

    // Random phases, each under its own slice length.
    foreach (slice_plan[p]) begin
      set_slice(slice_plan[p]);
      tx_quiet = (p == 1 || p == 4);
      rx_quiet <= (p == 2 || p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver stall while the sender keeps pushing: fills the block
        if (p == 1 && n == 20)
          hold_off_req <= 1'b1;
        // sender pauses until every response is back, then resumes
        if (p == 3 && n == 80)
          drain();
        send_random();
      end
    end

    drain();
    repeat (SLOTS + 8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
